@@ sv/ipid_pkg.sv @@
package ipid_pkg;

  // Fixed-point format and field widths
  localparam int FRAC_BITS  = 8;
  localparam int ACC_WIDTH  = 48;
  localparam int GAIN_W     = 16;
  localparam int GAIN_SHIFT = 8;
  localparam int RPM_W      = 15;
  localparam int DUTY_W     = 16;
  localparam int PULSE_W    = 16;
  localparam int ERR_W      = 32;
  localparam int D1_W       = ERR_W + 1;
  localparam int D2_W       = ERR_W + 2;
  localparam int PROD_W     = D2_W + GAIN_W + 1;
  localparam int SUM_W      = PROD_W + 2;
  localparam int INC_W      = SUM_W - GAIN_SHIFT;
  localparam int ADD_W      = ((ACC_WIDTH > INC_W) ? ACC_WIDTH : INC_W) + 1;

  // Setpoint = rpm * 1320 / 6000 in Q.FRAC_BITS = |rpm| * SP_NUM / SP_DEN
  localparam int SP_NUM      = 11 * (2 ** FRAC_BITS);
  localparam int SP_DEN      = 50;
  localparam int RECIP_SHIFT = RPM_W + 6;
  localparam int RECIP       = ((2 ** RECIP_SHIFT) + SP_DEN - 1) / SP_DEN;
  localparam int RECIP_W     = 16;
  localparam int QUO_W       = 9;
  localparam int REM_W       = 6;

  typedef logic [ERR_W-1:0] frac_tab_t [2**REM_W];

  // Fractional part of the setpoint for each remainder of |rpm| / 50
  function automatic frac_tab_t build_frac_tab();
    frac_tab_t tab;
    for (int i = 0; i < 2**REM_W; i++) begin
      tab[i] = ERR_W'((i * SP_NUM) / SP_DEN);
    end
    return tab;
  endfunction

  localparam frac_tab_t FRAC_TAB = build_frac_tab();

  // Configuration map
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_KP   = 3'd0,
    REG_KI   = 3'd1,
    REG_KD   = 3'd2,
    REG_RPM  = 3'd3,
    REG_DUTY = 3'd4
  } cfg_reg_t;

  localparam logic [GAIN_W-1:0] KP_RST   = 16'd5632;
  localparam logic [GAIN_W-1:0] KI_RST   = 16'd307;
  localparam logic [GAIN_W-1:0] KD_RST   = 16'd0;
  localparam logic [RPM_W-1:0]  RPM_RST  = 15'd300;
  localparam logic [DUTY_W-1:0] DUTY_RST = 16'd7000;

  // Cycles the setpoint path needs to settle after a register write
  localparam logic [1:0] HOLD_CYC = 2'd2;

endpackage

@@ sv/ipid_if.sv @@
interface ipid_in_if import ipid_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [PULSE_W-1:0] pulse_count;

  modport source (output valid, output pulse_count, input ready);
  modport sink   (input valid, input pulse_count, output ready);
endinterface

interface ipid_out_if import ipid_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty_magnitude;
  logic              forward;

  modport source (output valid, output duty_magnitude, output forward, input ready);
  modport sink   (input valid, input duty_magnitude, input forward, output ready);
endinterface

@@ sv/incremental_pid_motor_speed.sv @@
// Incremental PID speed controller, one encoder count in, one duty item out.
// Stages: capture, error, products, sum, accumulate, then the output register.
// Throughput: one item per cycle; each stage advances when the next one frees.
// Input ready drops after reset and after each register write while the
// rpm-to-count setpoint pipeline settles.
// Reset (synchronous, active low) restores register defaults and clears state.
module incremental_pid_motor_speed import ipid_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  ipid_in_if.sink           in_item,
  ipid_out_if.source        out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // Configuration registers
  logic [GAIN_W-1:0]        kp_r, ki_r, kd_r;
  logic signed [RPM_W-1:0]  rpm_r;
  logic [DUTY_W-1:0]        duty_r;
  logic [1:0]               hold_r;
  logic                     cfg_wr;

  // Pipeline
  logic                     v1_r, v2_r, v3_r, v4_r, v5_r, out_v_r;
  logic                     ld2, ld3, ld4, ld5, ld_out, in_ready;
  logic signed [PULSE_W-1:0] pulse_r;
  logic signed [ERR_W-1:0]  setpoint;
  logic signed [ERR_W+1:0]  err_full;
  logic signed [ERR_W-1:0]  err_sat;
  logic signed [ERR_W-1:0]  err_r, e1_r, e2_r;
  logic signed [D1_W-1:0]   d1_nxt, d1_r;
  logic signed [D2_W-1:0]   d2_nxt, d2_r;
  logic signed [PROD_W-1:0] pp_nxt, pi_nxt, pd_nxt, pp_r, pi_r, pd_r;
  logic signed [SUM_W-1:0]  sum;
  logic signed [INC_W-1:0]  inc_r;
  logic signed [ADD_W-1:0]  acc_add;
  logic [ADD_W-ACC_WIDTH:0] acc_hi;
  logic signed [ACC_WIDTH-1:0] acc_nxt, acc_r;
  logic [ACC_WIDTH:0]       acc_abs;
  logic [ACC_WIDTH:0]       acc_int;
  logic [DUTY_W-1:0]        mag_nxt, mag_r;
  logic                     fwd_nxt, fwd_r;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= KP_RST;
      ki_r   <= KI_RST;
      kd_r   <= KD_RST;
      rpm_r  <= RPM_RST;
      duty_r <= DUTY_RST;
    end else if (cfg_wr) begin
      unique case (paddr[ADDR_W-1:2])
        REG_KP:   kp_r   <= pwdata[GAIN_W-1:0];
        REG_KI:   ki_r   <= pwdata[GAIN_W-1:0];
        REG_KD:   kd_r   <= pwdata[GAIN_W-1:0];
        REG_RPM:  rpm_r  <= pwdata[RPM_W-1:0];
        REG_DUTY: duty_r <= pwdata[DUTY_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_KP:   prdata = DATA_W'(kp_r);
      REG_KI:   prdata = DATA_W'(ki_r);
      REG_KD:   prdata = DATA_W'(kd_r);
      REG_RPM:  prdata = DATA_W'(unsigned'(rpm_r));
      REG_DUTY: prdata = DATA_W'(duty_r);
      default:  prdata = '0;
    endcase
  end

  // Hold off inputs while the setpoint catches up with the rpm register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= HOLD_CYC;
    end else if (cfg_wr) begin
      hold_r <= HOLD_CYC;
    end else if (hold_r != '0) begin
      hold_r <= hold_r - 2'd1;
    end
  end

  ipid_setpoint u_setpoint (
    .clk      (clk),
    .rpm_in   (rpm_r),
    .setpoint (setpoint)
  );

  // ---------------- stage advance ----------------
  always_comb begin
    ld_out   = v5_r && (!out_v_r || out_item.ready);
    ld5      = v4_r && (!v5_r || ld_out);
    ld4      = v3_r && (!v4_r || ld5);
    ld3      = v2_r && (!v3_r || ld4);
    ld2      = v1_r && (!v2_r || ld3);
    in_ready = (!v1_r || ld2) && (hold_r == '0);
  end

  assign in_item.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready || ld2) v1_r <= in_item.valid && in_ready;
      if (ld2 || ld3)      v2_r <= ld2;
      if (ld3 || ld4)      v3_r <= ld3;
      if (ld4 || ld5)      v4_r <= ld4;
      if (ld5 || ld_out)   v5_r <= ld5;
      if (ld_out || out_item.ready) out_v_r <= ld_out;
    end
  end

  // Stage 1: capture the count
  always_ff @(posedge clk) begin
    if (in_item.valid && in_ready) begin
      pulse_r <= in_item.pulse_count;
    end
  end

  // Stage 2: saturated error and its differences, error history shifts
  always_comb begin
    err_full = (ERR_W+2)'(setpoint) - ((ERR_W+2)'(pulse_r) <<< FRAC_BITS);
    if ((&err_full[ERR_W+1:ERR_W-1]) || !(|err_full[ERR_W+1:ERR_W-1])) begin
      err_sat = err_full[ERR_W-1:0];
    end else begin
      err_sat = {err_full[ERR_W+1], {(ERR_W-1){~err_full[ERR_W+1]}}};
    end
    d1_nxt = D1_W'(err_sat) - D1_W'(e1_r);
    d2_nxt = D2_W'(err_sat) - (D2_W'(e1_r) <<< 1) + D2_W'(e2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r <= '0;
      e2_r <= '0;
    end else if (ld2) begin
      e1_r <= err_sat;
      e2_r <= e1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      err_r <= err_sat;
      d1_r  <= d1_nxt;
      d2_r  <= d2_nxt;
    end
  end

  // Stage 3: gain products
  always_comb begin
    pp_nxt = PROD_W'(signed'({1'b0, kp_r})) * PROD_W'(d1_r);
    pi_nxt = PROD_W'(signed'({1'b0, ki_r})) * PROD_W'(err_r);
    pd_nxt = PROD_W'(signed'({1'b0, kd_r})) * PROD_W'(d2_r);
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      pp_r <= pp_nxt;
      pi_r <= pi_nxt;
      pd_r <= pd_nxt;
    end
  end

  // Stage 4: sum, drop the gain fraction rounding toward minus infinity
  assign sum = SUM_W'(pp_r) + SUM_W'(pi_r) + SUM_W'(pd_r);

  always_ff @(posedge clk) begin
    if (ld4) begin
      inc_r <= sum[SUM_W-1:GAIN_SHIFT];
    end
  end

  // Stage 5: saturating accumulate
  always_comb begin
    acc_add = ADD_W'(acc_r) + ADD_W'(inc_r);
    acc_hi  = acc_add[ADD_W-1:ACC_WIDTH-1];
    if ((&acc_hi) || !(|acc_hi)) begin
      acc_nxt = acc_add[ACC_WIDTH-1:0];
    end else begin
      acc_nxt = {acc_add[ADD_W-1], {(ACC_WIDTH-1){~acc_add[ADD_W-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ld5) begin
      acc_r <= acc_nxt;
    end
  end

  // Output: truncate toward zero, clamp to the duty limit, split sign
  always_comb begin
    acc_abs = acc_r[ACC_WIDTH-1] ? (ACC_WIDTH+1)'(-(ACC_WIDTH+1)'(acc_r))
                                 : (ACC_WIDTH+1)'(acc_r);
    acc_int = acc_abs >> FRAC_BITS;
    mag_nxt = (acc_int > (ACC_WIDTH+1)'(duty_r)) ? duty_r : acc_int[DUTY_W-1:0];
    fwd_nxt = !acc_r[ACC_WIDTH-1] || (mag_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      mag_r <= mag_nxt;
      fwd_r <= fwd_nxt;
    end
  end

  assign out_item.valid          = out_v_r;
  assign out_item.duty_magnitude = mag_r;
  assign out_item.forward        = fwd_r;

endmodule

@@ sv/ipid_setpoint.sv @@
module ipid_setpoint import ipid_pkg::*; (
  input  logic                    clk,
  input  logic signed [RPM_W-1:0] rpm_in,
  output logic signed [ERR_W-1:0] setpoint
);

  logic [RPM_W-1:0]         abs_in;
  logic [RPM_W+RECIP_W-1:0] quo_prod;
  logic [RPM_W-1:0]         abs_r;
  logic                     neg_r;
  logic [QUO_W-1:0]         quo_r;
  logic [RPM_W-1:0]         rem_full;
  logic [REM_W-1:0]         rem;
  logic [ERR_W-1:0]         mag;
  logic signed [ERR_W-1:0]  setpoint_r;

  // Stage A: |rpm| / 50 by reciprocal multiply (exact for 15-bit values)
  always_comb begin
    abs_in   = rpm_in[RPM_W-1] ? RPM_W'(-rpm_in) : RPM_W'(rpm_in);
    quo_prod = (RPM_W+RECIP_W)'(abs_in) * (RPM_W+RECIP_W)'(RECIP);
  end

  always_ff @(posedge clk) begin
    abs_r <= abs_in;
    neg_r <= rpm_in[RPM_W-1];
    quo_r <= quo_prod[RECIP_SHIFT +: QUO_W];
  end

  // Stage B: whole part times SP_NUM plus table for the remainder, then sign
  always_comb begin
    rem_full = abs_r - RPM_W'(quo_r) * RPM_W'(SP_DEN);
    rem      = rem_full[REM_W-1:0];
    mag      = ERR_W'(quo_r) * ERR_W'(SP_NUM) + FRAC_TAB[rem];
  end

  always_ff @(posedge clk) begin
    setpoint_r <= neg_r ? -signed'(mag) : signed'(mag);
  end

  assign setpoint = setpoint_r;

endmodule
